>>> hdl/ufrm_pkg.sv
`timescale 1ns / 1ps

package ufrm_pkg;

  // default buffer depth in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  // idle timeout after reset, in ticks
  localparam logic [6:0] TIMEOUT_RESET = 7'd100;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_READ    = 2'd2,
    MODE_RELEASE = 2'd3
  } ufrm_mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [5:0] read_index;
  } ufrm_cmd_t;

  typedef struct packed {
    logic       frame_closed;
    logic [6:0] frame_length;
    logic [7:0] read_data;
    logic       frame_held;
    logic       byte_stored;
  } ufrm_rsp_t;

  // result fields known at accept time, plus the read-data select
  typedef struct packed {
    logic       closed;
    logic [6:0] length;
    logic       held;
    logic       stored;
    logic       rd_sel;
  } ufrm_stat_t;

endpackage

>>> hdl/ufrm_buf.sv
`timescale 1ns / 1ps

module ufrm_buf import ufrm_pkg::*; #(
  parameter int unsigned DEPTH = BUFFER_BYTES_DEF,
  parameter int unsigned AW    = $clog2(BUFFER_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ufrm_ctrl.sv
`timescale 1ns / 1ps

module ufrm_ctrl import ufrm_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned AW           = $clog2(BUFFER_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [6:0]    cfg_data,
  input  logic          accept,
  input  ufrm_cmd_t     cmd,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output ufrm_stat_t    stat
);

  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_BYTES - 1);
  localparam logic [6:0]    FULL_LEN = 7'(BUFFER_BYTES);

  logic [6:0]    timeout;
  logic [AW-1:0] write_position, write_position_next;
  logic [6:0]    held_length, held_length_next;
  logic          held_flag, held_flag_next;
  logic [6:0]    idle_countdown, idle_countdown_next;
  logic          idx_ok;
  logic          closed, stored;
  ufrm_mode_t    mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout <= cfg_data;
    end
  end

  assign mode   = ufrm_mode_t'(cmd.mode);
  assign idx_ok = 32'(cmd.read_index) < BUFFER_BYTES;

  always_comb begin
    write_position_next = write_position;
    held_length_next    = held_length;
    held_flag_next      = held_flag;
    idle_countdown_next = idle_countdown;
    closed              = 1'b0;
    stored              = 1'b0;
    case (mode)
      MODE_BYTE: begin
        if (held_flag) begin
          idle_countdown_next = timeout;
        end else if (write_position != '0 && idle_countdown == '0) begin
          // timed out: close with what is stored, drop this byte
          held_flag_next      = 1'b1;
          held_length_next    = 7'(write_position);
          write_position_next = '0;
          closed              = 1'b1;
        end else begin
          stored = 1'b1;
          if (write_position == '0) begin
            idle_countdown_next = timeout;
          end
          if (write_position == LAST_POS) begin
            held_flag_next      = 1'b1;
            held_length_next    = FULL_LEN;
            write_position_next = '0;
            idle_countdown_next = timeout;
            closed              = 1'b1;
          end else begin
            write_position_next = write_position + 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (idle_countdown != '0) begin
          idle_countdown_next = idle_countdown - 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (held_flag) begin
          held_flag_next      = 1'b0;
          held_length_next    = '0;
          idle_countdown_next = timeout;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      held_length    <= '0;
      held_flag      <= 1'b0;
      idle_countdown <= '0;
    end else if (accept) begin
      write_position <= write_position_next;
      held_length    <= held_length_next;
      held_flag      <= held_flag_next;
      idle_countdown <= idle_countdown_next;
    end
  end

  assign wr_en   = accept && stored;
  assign wr_addr = write_position;
  assign wr_data = cmd.byte_value;
  assign rd_en   = accept && mode == MODE_READ && idx_ok;
  assign rd_addr = AW'(cmd.read_index);

  assign stat.closed = closed;
  assign stat.length = held_length_next;
  assign stat.held   = held_flag_next;
  assign stat.stored = stored;
  assign stat.rd_sel = mode == MODE_READ && idx_ok;

  a_held_pos_zero : assert property (@(posedge clk) disable iff (rst)
    held_flag |-> write_position == '0)
    else $error("write position not cleared while frame held");

  a_len_when_free : assert property (@(posedge clk) disable iff (rst)
    !held_flag |-> held_length == '0)
    else $error("stale frame length with no frame held");

  a_no_store_held : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !held_flag)
    else $error("byte stored while frame held");

  a_close_sets_held : assert property (@(posedge clk) disable iff (rst)
    accept && closed |=> held_flag)
    else $error("frame closed but not held");

endmodule

>>> hdl/uart_rx_idle_timeout_framer.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// cmd       in   cmd_valid/cmd_ready    ufrm_cmd_t  (mode, byte_value, read_index)
// rsp       out  rsp_valid/rsp_ready    ufrm_rsp_t  (one result per item)
// cfg       in   cfg_write              cfg_data = idle_timeout_ticks
//
// one item per cycle sustained while rsp_ready is high; each result appears in the cycle after
// its item is accepted, set by the registered read of the frame buffer
// rst (synchronous) clears framing state and loads the timeout with 100;
// buffer contents are not cleared, there is no clearing pass
// a stalled result holds in the output register; cmd_ready stays high while
// that register is empty or being drained

module uart_rx_idle_timeout_framer import ufrm_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  ufrm_cmd_t  cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output ufrm_rsp_t  rsp
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  ufrm_stat_t    stat, rsp_stat;

  // single output stage; a draining result frees the slot in the same cycle
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  // state update and buffer access control
  ufrm_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .stat      (stat)
  );

  // frame buffer; a write lands at the accept edge, so a read in the next
  // item already sees it and no forwarding is needed
  ufrm_buf #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_ready) begin
      rsp_valid <= cmd_valid;
    end
  end

  // result fields ride next to the read data, which the buffer holds itself
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_stat <= stat;
    end
  end

  assign rsp.frame_closed = rsp_stat.closed;
  assign rsp.frame_length = rsp_stat.length;
  assign rsp.read_data    = rsp_stat.rd_sel ? rd_data : 8'h00;
  assign rsp.frame_held   = rsp_stat.held;
  assign rsp.byte_stored  = rsp_stat.stored;

endmodule

>>> tb/sv/ufrm_frame_monitor.sv
`timescale 1ns / 1ps

module ufrm_frame_monitor import ufrm_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [6:0]              cfg_data,
  input  logic                    cmd_valid,
  input  logic                    cmd_ready,
  input  ufrm_cmd_t               cmd,
  input  logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  ufrm_rsp_t               rsp,
  output int                      pending,
  output int                      errors,
  output logic [BUFFER_BYTES-1:0] written_map
);

  logic [7:0]              frame_mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] stored_bits;
  int unsigned             wr_pos;
  logic [6:0]              held_len;
  logic                    held;
  logic [6:0]              countdown;
  logic [6:0]              timeout_ticks;
  ufrm_rsp_t               frame_rsp_q[$];
  ufrm_rsp_t               want;
  int                      mismatch_count = 0;

  // next framer state and the result this item produces
  function automatic ufrm_rsp_t frame_step(input ufrm_cmd_t c);
    ufrm_rsp_t r;
    logic      drop;
    r = '0;
    drop = 1'b0;
    case (ufrm_mode_t'(c.mode))
      MODE_BYTE: begin
        if (held) begin
          countdown = timeout_ticks;
        end else begin
          if (wr_pos == 0) begin
            countdown = timeout_ticks;
          end else if (countdown == 0) begin
            // late byte closes the frame and is dropped
            held = 1'b1;
            held_len = 7'(wr_pos);
            wr_pos = 0;
            r.frame_closed = 1'b1;
            drop = 1'b1;
          end
          if (!drop) begin
            frame_mem[wr_pos] = c.byte_value;
            stored_bits[wr_pos] = 1'b1;
            r.byte_stored = 1'b1;
            if (wr_pos == BUFFER_BYTES - 1) begin
              held = 1'b1;
              held_len = 7'(BUFFER_BYTES);
              wr_pos = 0;
              countdown = timeout_ticks;
              r.frame_closed = 1'b1;
            end else begin
              wr_pos++;
            end
          end
        end
      end
      MODE_TICK: begin
        if (countdown != 0) countdown--;
      end
      MODE_READ: begin
        if (c.read_index < BUFFER_BYTES) r.read_data = frame_mem[c.read_index];
      end
      default: begin
        if (held) begin
          held = 1'b0;
          held_len = '0;
          countdown = timeout_ticks;
        end
      end
    endcase
    r.frame_length = held_len;
    r.frame_held = held;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_pos = 0;
      held_len = '0;
      held = 1'b0;
      countdown = '0;
      timeout_ticks = TIMEOUT_RESET;
      stored_bits = '0;
      frame_rsp_q.delete();
    end else begin
      if (cfg_write) timeout_ticks = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (frame_rsp_q.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual %p",
                   $time, rsp);
          mismatch_count++;
        end else begin
          want = frame_rsp_q.pop_front();
          check_field("frame_closed", 8'(want.frame_closed), 8'(rsp.frame_closed));
          check_field("frame_length", 8'(want.frame_length), 8'(rsp.frame_length));
          check_field("read_data", want.read_data, rsp.read_data);
          check_field("frame_held", 8'(want.frame_held), 8'(rsp.frame_held));
          check_field("byte_stored", 8'(want.byte_stored), 8'(rsp.byte_stored));
        end
      end
      if (cmd_valid && cmd_ready) frame_rsp_q.push_back(frame_step(cmd));
    end
    pending <= frame_rsp_q.size();
    errors <= mismatch_count;
    written_map <= stored_bits;
  end

endmodule

>>> tb/sv/tb_uart_rx_idle_timeout_framer.sv
`timescale 1ns / 1ps

module tb_uart_rx_idle_timeout_framer;
  import ufrm_pkg::*;

  localparam int unsigned BUF_BYTES       = BUFFER_BYTES_DEF;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_ITEMS     = 230;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  ufrm_cmd_t  cmd = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  ufrm_rsp_t  rsp;

  // shared with the monitor
  int                   pending;
  int                   errors;
  logic [BUF_BYTES-1:0] written_map;

  // idling knobs, changed per phase
  int   tx_gap_max = 18;
  int   rx_gap_max = 18;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int   rx_wait = 0;
  int   rx_gap_draw;
  int   cycle_count = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  uart_rx_idle_timeout_framer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  ufrm_frame_monitor #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .pending    (pending),
    .errors     (errors),
    .written_map(written_map)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uart_rx_idle_timeout_framer regression: fail");
      $finish;
    end
  end

  // result side: after each taken result, draw a stall length and drop ready for it;
  // ready is never lowered and raised in the same step
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_wait <= 0;
    end else if (rsp_ready) begin
      if (rsp_valid) begin
        if (hold_off_req && !hold_off_done) begin
          // one long hold-off so the block backs up and stalls its input
          rx_gap_draw = HOLD_OFF_CYCLES;
          hold_off_done <= 1'b1;
        end else begin
          rx_gap_draw = $urandom_range(0, rx_gap_max);
        end
        if (rx_gap_draw > 0) begin
          rsp_ready <= 1'b0;
          rx_wait <= rx_gap_draw;
        end
      end
    end else begin
      if (rx_wait <= 1) begin
        rsp_ready <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  function automatic ufrm_cmd_t cmd_of(input ufrm_mode_t m, input logic [7:0] b,
                                       input logic [5:0] idx);
    ufrm_cmd_t c;
    c.mode = m;
    c.byte_value = b;
    c.read_index = idx;
    return c;
  endfunction

  // offer one item after a random gap, return at the edge that takes it;
  // valid stays high straight into the next item when that gap is zero
  task automatic send_item(input ufrm_cmd_t c);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write, only ever issued with the block drained
  task automatic write_timeout(input logic [6:0] ticks);
    cfg_write <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one random phase at a given timeout and mode mix
  task automatic run_phase(input logic [6:0] ticks, input int byte_pct, input int tick_pct,
                           input int tx_gap, input int rx_gap, input bit hold);
    ufrm_cmd_t c;
    int        roll;
    int        idx;
    drain();
    write_timeout(ticks);
    tx_gap_max = tx_gap;
    rx_gap_max <= rx_gap;
    if (hold) hold_off_req <= 1'b1;
    repeat (PHASE_ITEMS) begin
      c.byte_value = 8'($urandom);
      c.read_index = 6'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < byte_pct) c.mode = MODE_BYTE;
      else if (roll < byte_pct + tick_pct) c.mode = MODE_TICK;
      else if (roll % 4 != 0) c.mode = MODE_READ;
      else c.mode = MODE_RELEASE;
      if (c.mode == MODE_READ) begin
        // only read back entries some frame has already written
        idx = c.read_index;
        repeat (BUF_BYTES) if (!written_map[idx]) idx = (idx + 1) % BUF_BYTES;
        if (written_map[idx]) c.read_index = 6'(idx);
        else c.mode = MODE_TICK;
      end
      send_item(c);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // nothing framed yet
    send_item(cmd_of(MODE_RELEASE, 8'h00, 6'd0));   // release with no frame held
    send_item(cmd_of(MODE_TICK, 8'hFF, 6'd63));     // tick with countdown at zero

    // short timeout: frame closed by a late byte
    drain();
    write_timeout(7'd2);
    send_item(cmd_of(MODE_BYTE, 8'h00, 6'd63));     // first byte arms countdown
    send_item(cmd_of(MODE_BYTE, 8'hFF, 6'd0));
    send_item(cmd_of(MODE_READ, 8'h00, 6'd0));      // read with no frame held
    send_item(cmd_of(MODE_READ, 8'hFF, 6'd1));
    send_item(cmd_of(MODE_TICK, 8'h00, 6'd0));
    send_item(cmd_of(MODE_TICK, 8'h00, 6'd0));
    send_item(cmd_of(MODE_TICK, 8'h00, 6'd0));      // stays at zero
    send_item(cmd_of(MODE_BYTE, 8'hAA, 6'd0));      // late byte closes, dropped
    send_item(cmd_of(MODE_BYTE, 8'h55, 6'd0));      // dropped while held
    send_item(cmd_of(MODE_READ, 8'h00, 6'd1));      // read while held
    send_item(cmd_of(MODE_RELEASE, 8'hFF, 6'd63));
    send_item(cmd_of(MODE_RELEASE, 8'h00, 6'd0));   // nothing held, ignored

    // zero timeout: the second byte of a frame closes it
    drain();
    write_timeout(7'd0);
    send_item(cmd_of(MODE_BYTE, 8'h80, 6'd0));
    send_item(cmd_of(MODE_BYTE, 8'h7F, 6'd0));
    send_item(cmd_of(MODE_RELEASE, 8'h00, 6'd0));
    send_item(cmd_of(MODE_BYTE, 8'h01, 6'd0));
    send_item(cmd_of(MODE_TICK, 8'h00, 6'd0));
    send_item(cmd_of(MODE_BYTE, 8'hFE, 6'd0));
    send_item(cmd_of(MODE_RELEASE, 8'h00, 6'd0));

    // random phases: timeout, byte %, tick %, sender gap, receiver gap, hold-off
    run_phase(7'd100, 80, 8, 18, 18, 1'b0);       // byte-heavy, fills whole frames
    run_phase(7'd1, 50, 30, 0, 0, 1'b0);          // back to back, no idling
    run_phase(7'd127, 75, 15, 18, 18, 1'b0);
    run_phase(7'd5, 55, 30, 0, 18, 1'b1);         // sender flat out over the long stall
    run_phase(7'd0, 50, 20, 18, 0, 1'b0);
    run_phase(7'($urandom_range(1, 127)), 40, 45, 18, 18, 1'b0);
    run_phase(7'd64, 65, 25, 0, 18, 1'b0);
    run_phase(7'($urandom_range(2, 12)), 55, 30, 5, 5, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("uart_rx_idle_timeout_framer regression: pass");
    end else begin
      $display("uart_rx_idle_timeout_framer regression: fail");
    end
    $finish;
  end

endmodule
